FILE: sv/fra_pkg.sv
// shared constants, codes and types of the fraction arithmetic block
package fra_pkg;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned PROD_W        = 2 * OPERAND_WIDTH;
  localparam int unsigned RAW_NUM_W     = PROD_W + 1;
  localparam int unsigned MAG_W         = PROD_W;
  localparam int unsigned CNT_W         = $clog2(MAG_W + 1);
  localparam int unsigned NUM_OUT_W     = 33;
  localparam int unsigned DEN_OUT_W     = 32;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  // which product the shared multiplier forms
  typedef enum logic [1:0] {
    MSTEP_NUM   = 2'd0,
    MSTEP_DEN   = 2'd1,
    MSTEP_CROSS = 2'd2
  } mstep_e;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL0 = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_MUL2 = 8'b0000_1000,
    S_COMB = 8'b0001_0000,
    S_GCD  = 8'b0010_0000,
    S_DIVN = 8'b0100_0000,
    S_DIVD = 8'b1000_0000
  } state_e;

  // handshake of an iterative unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } unit_rsp_t;

endpackage

FILE: sv/fraction_arith_reduce.sv
// top level: sequencer for fraction arithmetic with gcd reduction
// when the raw numerator or denominator is zero the reduction is skipped; otherwise the
//   binary gcd runs (one shift or subtract per cycle) and the shared divider makes two
//   passes, first for the numerator and then for the denominator
// throughput: one beat at a time; busy stays high until the result strobe, so the
//   rate is set by the gcd loop and the two passes through the shared divider
// results are strobed for one cycle and cannot be stalled; reset clears the sequencer
module fraction_arith_reduce import fra_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action_i,
  input  logic signed [OPERAND_WIDTH-1:0] num_a_i,
  input  logic signed [OPERAND_WIDTH-1:0] den_a_i,
  input  logic signed [OPERAND_WIDTH-1:0] num_b_i,
  input  logic signed [OPERAND_WIDTH-1:0] den_b_i,
  output logic                          valid_o,
  output logic signed [NUM_OUT_W-1:0]   num_out_o,
  output logic signed [DEN_OUT_W-1:0]   den_out_o,
  output logic                          zero_den_o
);

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  // latched operands of the beat in flight
  action_e                         op_q, op_d;
  logic signed [OPERAND_WIDTH-1:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;

  // products from the shared multiplier
  logic signed [PROD_W-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic signed [PROD_W-1:0] prod;
  mstep_e                   mstep;

  // raw and reduced fraction
  logic signed [RAW_NUM_W-1:0] num_q, num_d, raw_num;
  logic signed [PROD_W-1:0]    den_q, den_d, raw_den;
  logic [MAG_W-1:0]            nq_q, nq_d;
  logic [MAG_W-1:0]            mag_num, mag_den;
  logic signed [RAW_NUM_W-1:0] neg_num;
  logic signed [PROD_W-1:0]    neg_den;
  logic signed [RAW_NUM_W-1:0] red_num;
  logic signed [MAG_W:0]       red_den;

  // output registers
  logic signed [NUM_OUT_W-1:0] num_out_q, num_out_d;
  logic signed [DEN_OUT_W-1:0] den_out_q, den_out_d;
  logic                        zden_q, zden_d;

  // shared units
  unit_req_t        gcd_req, div_req;
  unit_rsp_t        gcd_rsp, div_rsp;
  logic [MAG_W-1:0] gcd_g, div_quo, div_dividend;

  // marks that the gcd of the current beat has been launched
  logic gcd_started_q, gcd_started_d;

  assign busy = (state_q != S_IDLE);

  // product order: numerator term, denominator, cross term
  always_comb begin
    case (state_q)
      S_MUL0:  mstep = MSTEP_NUM;
      S_MUL1:  mstep = MSTEP_DEN;
      default: mstep = MSTEP_CROSS;
    endcase
  end

  fra_mul u_mul (
    .op_i   (op_q),
    .step_i (mstep),
    .a_i    (a_q),
    .b_i    (b_q),
    .c_i    (c_q),
    .d_i    (d_q),
    .prod_o (prod)
  );

  // raw fraction before reduction; equal denominators skip the cross terms
  always_comb begin
    raw_num = RAW_NUM_W'(p0_q);
    raw_den = p1_q;
    case (op_q)
      ACT_ADD: begin
        if (b_q == d_q) begin
          raw_num = RAW_NUM_W'(a_q) + RAW_NUM_W'(c_q);
          raw_den = PROD_W'(b_q);
        end else begin
          raw_num = RAW_NUM_W'(p0_q) + RAW_NUM_W'(p2_q);
        end
      end
      ACT_SUB: begin
        if (b_q == d_q) begin
          raw_num = RAW_NUM_W'(a_q) - RAW_NUM_W'(c_q);
          raw_den = PROD_W'(b_q);
        end else begin
          raw_num = RAW_NUM_W'(p0_q) - RAW_NUM_W'(p2_q);
        end
      end
      default: begin
        raw_num = RAW_NUM_W'(p0_q);
        raw_den = p1_q;
      end
    endcase
  end

  // magnitudes fed to the gcd and the divider
  assign neg_num = -num_q;
  assign neg_den = -den_q;
  assign mag_num = num_q[RAW_NUM_W-1] ? neg_num[MAG_W-1:0] : num_q[MAG_W-1:0];
  assign mag_den = den_q[PROD_W-1] ? neg_den[MAG_W-1:0] : den_q[MAG_W-1:0];

  // signs go back on after the exact division
  assign red_num = num_q[RAW_NUM_W-1] ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});
  assign red_den = den_q[PROD_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  assign div_dividend = (state_q == S_GCD) ? mag_num : mag_den;

  fra_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .x_i    (mag_num),
    .y_i    (mag_den),
    .rsp_o  (gcd_rsp),
    .g_o    (gcd_g)
  );

  fra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (gcd_g),
    .rsp_o      (div_rsp),
    .quo_o      (div_quo)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    valid_d       = 1'b0;
    op_d          = op_q;
    a_d           = a_q;
    b_d           = b_q;
    c_d           = c_q;
    d_d           = d_q;
    p0_d          = p0_q;
    p1_d          = p1_q;
    p2_d          = p2_q;
    num_d         = num_q;
    den_d         = den_q;
    nq_d          = nq_q;
    num_out_d     = num_out_q;
    den_out_d     = den_out_q;
    zden_d        = zden_q;
    gcd_req.start = 1'b0;
    div_req.start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = action_e'(action_i);
          a_d     = num_a_i;
          b_d     = den_a_i;
          c_d     = num_b_i;
          d_d     = den_b_i;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        p0_d    = prod;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        p1_d    = prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p2_d    = prod;
        state_d = S_COMB;
      end
      S_COMB: begin
        num_d = raw_num;
        den_d = raw_den;
        if (raw_num == '0 || raw_den == '0) begin
          // zero part: no reduction
          num_out_d = NUM_OUT_W'(raw_num);
          den_out_d = DEN_OUT_W'(raw_den);
          zden_d    = (raw_den == '0);
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        // first cycle here starts the gcd on the registered raw parts
        if (gcd_rsp.done) begin
          div_req.start = 1'b1;
          state_d       = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          nq_d          = div_quo;
          div_req.start = 1'b1;
          state_d       = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          num_out_d = NUM_OUT_W'(red_num);
          den_out_d = DEN_OUT_W'(red_den);
          zden_d    = 1'b0;
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (state_q == S_GCD && !gcd_rsp.busy && !gcd_rsp.done && !gcd_started_q) begin
      gcd_req.start = 1'b1;
    end
  end

  assign gcd_started_d = (state_q == S_GCD) ? (gcd_started_q | gcd_req.start) : 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      valid_q       <= 1'b0;
      gcd_started_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      valid_q       <= valid_d;
      gcd_started_q <= gcd_started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    c_q       <= c_d;
    d_q       <= d_d;
    p0_q      <= p0_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    num_q     <= num_d;
    den_q     <= den_d;
    nq_q      <= nq_d;
    num_out_q <= num_out_d;
    den_out_q <= den_out_d;
    zden_q    <= zden_d;
  end

  assign valid_o    = valid_q;
  assign num_out_o  = num_out_q;
  assign den_out_o  = den_out_q;
  assign zero_den_o = zden_q;

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while the sequencer is busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_den_o) |-> (den_out_o == '0))
    else $error("zero denominator flag with nonzero denominator");
`endif

endmodule

FILE: sv/fra_mul.sv
// shared signed multiplier with operand selection per product step
module fra_mul import fra_pkg::*; (
  input  action_e                           op_i,
  input  mstep_e                            step_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_i,
  input  logic signed [OPERAND_WIDTH-1:0]   c_i,
  input  logic signed [OPERAND_WIDTH-1:0]   d_i,
  output logic signed [PROD_W-1:0]          prod_o
);

  logic signed [OPERAND_WIDTH-1:0] opa;
  logic signed [OPERAND_WIDTH-1:0] opb;

  always_comb begin
    opa = a_i;
    opb = d_i;
    case (step_i)
      MSTEP_NUM: begin
        opa = a_i;
        opb = (op_i == ACT_MUL) ? c_i : d_i;
      end
      MSTEP_DEN: begin
        opa = b_i;
        opb = (op_i == ACT_DIV) ? c_i : d_i;
      end
      MSTEP_CROSS: begin
        opa = c_i;
        opb = b_i;
      end
      default: begin
        opa = a_i;
        opb = d_i;
      end
    endcase
  end

  assign prod_o = PROD_W'(opa) * PROD_W'(opb);

endmodule

FILE: sv/fra_gcd.sv
// binary gcd engine, one shift or subtract step per cycle
module fra_gcd import fra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  unit_req_t          req_i,
  input  logic [MAG_W-1:0]   x_i,
  input  logic [MAG_W-1:0]   y_i,
  output unit_rsp_t          rsp_o,
  output logic [MAG_W-1:0]   g_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [MAG_W-1:0] x_q, x_d, y_q, y_d, g_q, g_d;
  logic [CNT_W-1:0] k_q, k_d;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    x_d    = x_q;
    y_d    = y_q;
    k_d    = k_q;
    g_d    = g_q;
    if (req_i.start) begin
      x_d   = x_i;
      y_d   = y_i;
      k_d   = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (x_q == y_q) begin
        g_d    = x_q << k_q;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + CNT_W'(1);
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_q > y_q) begin
        x_d = x_q - y_q;
      end else begin
        y_d = y_q - x_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = run_q;
  assign g_o        = g_q;

endmodule

FILE: sv/fra_div.sv
// restoring divider, one quotient bit per cycle
module fra_div import fra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  unit_req_t          req_i,
  input  logic [MAG_W-1:0]   dividend_i,
  input  logic [MAG_W-1:0]   divisor_i,
  output unit_rsp_t          rsp_o,
  output logic [MAG_W-1:0]   quo_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [MAG_W:0]   rem_sh;
  logic [MAG_W:0]   diff;

  assign rem_sh = {rem_q, quo_q[MAG_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(MAG_W);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = diff[MAG_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[MAG_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = run_q;
  assign quo_o      = quo_q;

endmodule
